FILE: hdl/sha256_stream_hasher_assert.svh
// ---------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the cycle after its antecedent.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sha256_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the controller state type.
// ---------------------------------------------------------------------------
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_START = 7'd56;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] hash_init(input logic [2:0] i);
        logic [31:0] h;
        begin
            unique case (i)
                3'd0: h = 32'h6a09e667;
                3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372;
                3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f;
                3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab;
                3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        begin
            return (v >> n) | (v << (32 - n));
        end
    endfunction

endpackage

FILE: hdl/sha256_stream_hasher.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide SHA-256 with padding, length field and word-serial digest output.
// ---------------------------------------------------------------------------
// A message byte is accepted while the current 64-byte block is still
// filling. The item that fills a block holds the input off while the block
// is compressed: the 64 bytes are read back from the byte memory and packed
// into the sixteen-word schedule window, the 64 rounds run, one per cycle,
// and the round state then hands over to the update state, which adds the
// working words into the hash words. On end of message the padding bytes
// are written into the byte memory one a cycle, from the fill position up
// to the end of the block, and the block is compressed. When the 0x80 byte
// lands beyond byte 55, a second padding pass over a whole block and a
// second compression follow. A message whose last byte filled a block
// first compresses that block and then pads a fresh one. After that the
// eight digest words leave on the master side, word 0 first, one per
// accepted cycle, and the hash state returns to the initial values for the
// next message. The closing item therefore holds the input off through all
// of this, plus any stall on the master side.
// ---------------------------------------------------------------------------
`include "sha256_stream_hasher_assert.svh"

module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_position
    output logic        m_tlast    // last_word
);

    sha256_pkg::state_t state_reg, state_next;

    // Byte memory for the block under construction.
    logic [7:0]  buf_mem [0:63];
    logic        buf_we;
    logic [5:0]  buf_waddr;
    logic [7:0]  buf_wdata;
    logic [5:0]  buf_raddr;
    logic [7:0]  buf_rdata_reg;

    logic [6:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] h_reg [0:7];
    logic [31:0] a_reg [0:7];
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] word_reg, word_next;
    logic        final_reg, final_next;
    logic        pend_reg, pend_next;
    logic        pad_two_reg, pad_two_next;

    // Schedule window: the sixteen most recent message words.
    logic [31:0] win_reg [0:15];

    logic        s_fire;
    logic        has_byte;
    logic        eom;
    logic [31:0] load_word;

    assign s_fire    = s_tvalid && s_tready;
    assign has_byte  = s_tuser;
    assign eom       = s_tlast;
    assign s_tready  = (state_reg == sha256_pkg::ST_IDLE);
    assign load_word = {word_reg[23:0], buf_rdata_reg};

    // ---- round datapath --------------------------------------------------
    logic [31:0] wt, s0, s1, t1, t2, ch, maj, e_sig, a_sig;
    logic [5:0]  rnd;
    assign rnd = cnt_reg[5:0];

    // During the first sixteen rounds the window rotates, so that it holds
    // words 0 to 15 again when the schedule expansion starts.
    always_comb
    begin
        s0 = sha256_pkg::rotr(win_reg[1], 7) ^ sha256_pkg::rotr(win_reg[1], 18)
             ^ (win_reg[1] >> 3);
        s1 = sha256_pkg::rotr(win_reg[14], 17) ^ sha256_pkg::rotr(win_reg[14], 19)
             ^ (win_reg[14] >> 10);
        if (rnd < 6'd16)
        begin
            wt = win_reg[0];
        end
        else
        begin
            wt = win_reg[0] + s0 + win_reg[9] + s1;
        end
        e_sig = sha256_pkg::rotr(a_reg[4], 6) ^ sha256_pkg::rotr(a_reg[4], 11)
                ^ sha256_pkg::rotr(a_reg[4], 25);
        a_sig = sha256_pkg::rotr(a_reg[0], 2) ^ sha256_pkg::rotr(a_reg[0], 13)
                ^ sha256_pkg::rotr(a_reg[0], 22);
        ch    = (a_reg[4] & a_reg[5]) ^ (~a_reg[4] & a_reg[6]);
        maj   = (a_reg[0] & a_reg[1]) ^ (a_reg[0] & a_reg[2]) ^ (a_reg[1] & a_reg[2]);
        t1    = a_reg[7] + e_sig + ch + sha256_pkg::round_k(rnd) + wt;
        t2    = a_sig + maj;
    end

    // ---- byte memory -----------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata_reg <= buf_mem[buf_raddr];
    end

    // ---- control ---------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha256_pkg::ST_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            final_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            pad_two_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            final_reg   <= final_next;
            pend_reg    <= pend_next;
            pad_two_reg <= pad_two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        final_next   = final_reg;
        pend_next    = pend_reg;
        pad_two_next = pad_two_reg;
        word_next    = word_reg;
        buf_we       = 1'b0;
        buf_waddr    = fill_reg[5:0];
        buf_wdata    = s_tdata;
        buf_raddr    = cnt_reg[5:0];
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (has_byte)
                    begin
                        buf_we    = 1'b1;
                        len_next  = len_reg + 64'd8;
                        fill_next = fill_reg + 7'd1;
                    end
                    if (has_byte && (fill_reg == 7'd63))
                    begin
                        // Block full: compress it, then pad a fresh block if closed.
                        fill_next  = '0;
                        pend_next  = eom;
                        cnt_next   = '0;
                        state_next = sha256_pkg::ST_LOAD;
                    end
                    else if (eom)
                    begin
                        final_next = 1'b1;
                        state_next = sha256_pkg::ST_PAD;
                        cnt_next   = '0;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                // Write one padding byte per cycle at the fill position.
                buf_we    = 1'b1;
                fill_next = fill_reg + 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    buf_wdata    = sha256_pkg::PAD_BYTE;
                    pad_two_next = (fill_reg > 7'd55);
                end
                else if (!pad_two_reg && (fill_reg >= sha256_pkg::LEN_START))
                begin
                    buf_wdata = len_reg[{3'(7'd63 - fill_reg), 3'b000} +: 8];
                end
                else
                begin
                    buf_wdata = 8'h00;
                end
                cnt_next = 7'd1;
                if (fill_reg == 7'd63)
                begin
                    fill_next  = '0;
                    cnt_next   = '0;
                    state_next = sha256_pkg::ST_LOAD;
                end
            end
            sha256_pkg::ST_LOAD:
            begin
                // 64 byte reads, packed into words (the read data is registered).
                cnt_next  = cnt_reg + 7'd1;
                word_next = load_word;
                if (cnt_reg == 7'd64)
                begin
                    cnt_next   = '0;
                    state_next = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd64)
                begin
                    cnt_next   = '0;
                    state_next = sha256_pkg::ST_UPDATE;
                end
            end
            sha256_pkg::ST_UPDATE:
            begin
                if (final_reg)
                begin
                    if (pad_two_reg)
                    begin
                        pad_two_next = 1'b0;
                        cnt_next     = 7'd1;
                        state_next   = sha256_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha256_pkg::ST_EMIT;
                    end
                end
                else if (pend_reg)
                begin
                    // The message closed on a full block: pad a fresh one.
                    pend_next  = 1'b0;
                    final_next = 1'b1;
                    cnt_next   = '0;
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_EMIT:
            begin
                if (m_tready)
                begin
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd7)
                    begin
                        cnt_next   = '0;
                        final_next = 1'b0;
                        len_next   = '0;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    // ---- working words, window and hash state ---------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::hash_init(3'(i));
            end
        end
        else if (state_reg == sha256_pkg::ST_UPDATE)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + a_reg[i];
            end
        end
        else if ((state_reg == sha256_pkg::ST_EMIT) && m_tready && (cnt_reg == 7'd7))
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::hash_init(3'(i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == sha256_pkg::ST_LOAD) && (cnt_reg[1:0] == 2'd0)
            && (cnt_reg != 7'd0))
        begin
            // Each completed word enters the window at the tail.
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= load_word;
            if (cnt_reg == 7'd64)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    a_reg[i] <= h_reg[i];
                end
            end
        end
        else if ((state_reg == sha256_pkg::ST_ROUND) && (cnt_reg != 7'd64))
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= wt;
            a_reg[7] <= a_reg[6];
            a_reg[6] <= a_reg[5];
            a_reg[5] <= a_reg[4];
            a_reg[4] <= a_reg[3] + t1;
            a_reg[3] <= a_reg[2];
            a_reg[2] <= a_reg[1];
            a_reg[1] <= a_reg[0];
            a_reg[0] <= t1 + t2;
        end
    end

    assign m_tvalid = (state_reg == sha256_pkg::ST_EMIT);
    assign m_tuser  = cnt_reg[2:0];
    assign m_tdata  = h_reg[cnt_reg[2:0]];
    assign m_tlast  = (cnt_reg[2:0] == 3'd7);

    `SHA_ASSERT_IMPL(a_ready_idle, clk, rst_n, s_tready,
        state_reg == sha256_pkg::ST_IDLE, "ready outside idle")
    `SHA_ASSERT_IMPL(a_valid_emit, clk, rst_n, m_tvalid,
        !s_tready, "digest output while accepting input")
    `SHA_ASSERT_NEXT(a_last_done, clk, rst_n, m_tvalid && m_tready && m_tlast,
        state_reg == sha256_pkg::ST_IDLE, "did not return to idle after digest")

endmodule
